@@ design/clcd_pkg.sv @@
// Shared types and constants for the character-LCD expander byte stream block.
// No dependencies; every other design file uses this package.
package clcd_pkg;

    localparam logic [1:0] REQ_PUT_CHAR = 2'd0;
    localparam logic [1:0] REQ_MOVE     = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_RAW      = 2'd3;

    localparam logic [1:0] CFG_LINE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] CFG_BACKLIGHT    = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW_ODD_OFFS  = 8'h40;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [1:0] row;
        logic [7:0] command_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       long_wait;
        logic       last;
    } t_res;

    // One request's controller bytes: first byte with its RS, optional second command.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic       rs0;
        logic [7:0] byte1;
        logic       backlight;
    } t_entry;

    function automatic logic [7:0] ddram_cmd(input logic [6:0] col, input logic [2:0] row,
                                             input logic [5:0] col_count);
        logic [7:0] addr;
        addr = {2'b00, col[5:0]};
        if (row[0]) addr = addr + ROW_ODD_OFFS;
        if (row[1]) addr = addr + {2'b00, col_count};
        return addr | CMD_SET_DDRAM;
    endfunction

endpackage

@@ design/clcd_front.sv @@
// Front end: configuration registers, cursor tracking and request classification.
// Depends on clcd_pkg.
module clcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [5:0]          i_cfg_data,
    input  logic                i_take,
    input  clcd_pkg::t_req      i_req,
    output clcd_pkg::t_entry    o_entry
);
    import clcd_pkg::*;

    logic [2:0] r_line_count;
    logic [5:0] r_column_count;
    logic       r_backlight;
    logic [6:0] r_col, n_col;
    logic [2:0] r_row, n_row;

    logic [6:0] col_inc;
    logic [6:0] col_put;
    logic [2:0] row_adv;
    logic [2:0] row_put;
    logic       wrap;

    always_comb begin
        col_inc = (i_req.char_code == CHAR_NEWLINE) ? {1'b0, r_column_count} : r_col + 7'd1;
        wrap    = col_inc >= {1'b0, r_column_count};
        col_put = wrap ? 7'd0 : col_inc;
        row_adv = wrap ? r_row + 3'd1 : r_row;
        row_put = (row_adv >= r_line_count) ? 3'd0 : row_adv;
    end

    always_comb begin
        n_col             = r_col;
        n_row             = r_row;
        o_entry.two       = 1'b0;
        o_entry.byte0     = i_req.command_byte;
        o_entry.rs0       = 1'b0;
        o_entry.byte1     = CMD_HOME;
        o_entry.backlight = r_backlight;
        unique case (i_req.req_type)
            REQ_PUT_CHAR: begin
                n_col = col_put;
                n_row = row_put;
                if (i_req.char_code == CHAR_NEWLINE) begin
                    o_entry.byte0 = ddram_cmd(col_put, row_put, r_column_count);
                end else begin
                    o_entry.two   = 1'b1;
                    o_entry.byte0 = i_req.char_code;
                    o_entry.rs0   = 1'b1;
                    o_entry.byte1 = ddram_cmd(col_put, row_put, r_column_count);
                end
            end
            REQ_MOVE: begin
                n_col         = {1'b0, i_req.column};
                n_row         = {1'b0, i_req.row};
                o_entry.byte0 = ddram_cmd({1'b0, i_req.column}, {1'b0, i_req.row},
                                          r_column_count);
            end
            REQ_CLEAR: begin
                n_col         = 7'd0;
                n_row         = 3'd0;
                o_entry.two   = 1'b1;
                o_entry.byte0 = CMD_CLEAR;
                o_entry.byte1 = CMD_HOME;
            end
            REQ_RAW: begin
                o_entry.byte0 = i_req.command_byte;
            end
            default: begin
                o_entry.byte0 = i_req.command_byte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count   <= 3'd2;
            r_column_count <= 6'd16;
            r_backlight    <= 1'b1;
            r_col          <= 7'd0;
            r_row          <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LINE_COUNT:   r_line_count   <= i_cfg_data[2:0];
                    CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                    CFG_BACKLIGHT:    r_backlight    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

@@ design/clcd_queue.sv @@
// Short register queue of request entries between front and back ends.
// Depends on clcd_pkg.
module clcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  clcd_pkg::t_entry  i_data,
    output logic              o_full,
    input  logic              i_rd,
    output clcd_pkg::t_entry  o_data,
    output logic              o_empty
);
    import clcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (i_rd) r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            if (i_wr && !i_rd)      r_count <= r_count + 1'b1;
            else if (!i_wr && i_rd) r_count <= r_count - 1'b1;
        end
    end

endmodule

@@ design/clcd_back.sv @@
// Back end: expands each entry into nibble strobes and holds the output register.
// Depends on clcd_pkg.
module clcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  clcd_pkg::t_entry  i_entry,
    input  logic              i_avail,
    output logic              o_take,
    output clcd_pkg::t_res    o_res,
    output logic              o_empty,
    input  logic              i_pop
);
    import clcd_pkg::*;

    logic       r_busy;
    t_entry     r_entry;
    logic [2:0] r_step;
    logic       r_out_valid;
    t_res       r_out;

    logic       advance;
    logic       emit;
    logic       final_step;
    logic [7:0] val;
    logic       rs;
    logic [3:0] nib;
    t_res       res;

    always_comb begin
        advance    = !r_out_valid || i_pop;
        emit       = r_busy && advance;
        final_step = (r_step == (r_entry.two ? 3'd7 : 3'd3));
        val        = r_step[2] ? r_entry.byte1 : r_entry.byte0;
        rs         = r_step[2] ? 1'b0 : r_entry.rs0;
        nib        = r_step[1] ? val[3:0] : val[7:4];
        res.expander_byte = {nib, r_entry.backlight, !r_step[0], 1'b0, rs};
        res.long_wait     = (r_step[1:0] == 2'd3) && !rs && (val[7:2] == 6'd0);
        res.last          = final_step;
        o_take     = i_avail && (!r_busy || (emit && final_step));
    end

    assign o_res   = r_out;
    assign o_empty = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (o_take) r_entry <= i_entry;
        if (emit)   r_out   <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit)         r_out_valid <= 1'b1;
            else if (i_pop)   r_out_valid <= 1'b0;
            if (o_take) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (emit) begin
                r_step <= r_step + 3'd1;
                if (final_step) r_busy <= 1'b0;
            end
        end
    end

endmodule

@@ design/char_lcd_expander_byte_stream_top.sv @@
// Top level of the character-LCD expander byte stream block.
// Depends on clcd_pkg, clcd_front, clcd_queue and clcd_back.
//
//  channel  | handshake        | payload
//  request  | push / full      | i_req  (clcd_pkg::t_req)
//  result   | pop / empty      | o_res  (clcd_pkg::t_res)
//  config   | i_cfg_we         | i_cfg_idx, i_cfg_data
//
// The back end emits one expander byte per cycle while pops keep up: 4 for move, raw and
// newline, 8 for put char and clear. A push is accepted whenever the entry queue has
// room; the queue holds QUEUE_DEPTH requests. Reset is synchronous and empties both
// sides; cursor goes to 0,0. A stalled pop holds the output byte and the back end.
module char_lcd_expander_byte_stream_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  clcd_pkg::t_req   i_req,
    output logic             empty,
    input  logic             pop,
    output clcd_pkg::t_res   o_res,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [5:0]       i_cfg_data
);
    import clcd_pkg::*;

    t_entry entry_in;
    t_entry entry_out;
    logic   take_in;
    logic   q_empty;
    logic   back_take;

    assign take_in = push && !full;

    clcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take_in),
        .i_req      (i_req),
        .o_entry    (entry_in)
    );

    clcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (take_in),
        .i_data  (entry_in),
        .o_full  (full),
        .i_rd    (back_take),
        .o_data  (entry_out),
        .o_empty (q_empty)
    );

    clcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (entry_out),
        .i_avail (!q_empty),
        .o_take  (back_take),
        .o_res   (o_res),
        .o_empty (empty),
        .i_pop   (pop)
    );

endmodule

@@ design/clcd_checker.sv @@
// Port-level checks on the result stream of the expander byte stream block.
// Depends on clcd_pkg; bound to char_lcd_expander_byte_stream_top.
module clcd_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            empty,
    input  logic            pop,
    input  clcd_pkg::t_res  o_res
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_res))
        else $error("waiting result changed");

    a_strobe_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.expander_byte[2] |-> !o_res.last && !o_res.long_wait)
        else $error("strobe byte flagged as last or long wait");

    a_wait_is_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.long_wait |-> !o_res.expander_byte[0]
                                      && o_res.expander_byte[7:6] == 2'b00)
        else $error("long wait on data byte or large command");

    a_rw_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !o_res.expander_byte[1])
        else $error("RW bit set");

endmodule

bind char_lcd_expander_byte_stream_top clcd_checker u_clcd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_expander_byte_stream_top: random and directed LCD
// requests, a cursor-tracking scoreboard and randomly stalled transfers on both queue ports.
// Depends on clcd_pkg and the top level of the block.
module testbench;

    import clcd_pkg::*;

    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam logic [7:0] BIT_E       = 8'h04;
    localparam int         STALL_LIMIT = 3000;

    class lcd_stream_model;
        t_res       pending_bytes[$];
        int         errors;
        logic [2:0] line_count;
        logic [5:0] column_count;
        logic       backlight_on;
        logic [6:0] cursor_col;
        logic [2:0] cursor_row;

        function new();
            errors       = 0;
            line_count   = 3'd2;
            column_count = 6'd16;
            backlight_on = 1'b1;
            cursor_col   = '0;
            cursor_row   = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [5:0] data);
            case (idx)
                CFG_LINE_COUNT:   line_count   = data[2:0];
                CFG_COLUMN_COUNT: column_count = data;
                CFG_BACKLIGHT:    backlight_on = data[0];
                default: ;
            endcase
        endfunction

        // One controller byte becomes four expander bytes: high nibble, then low, each strobed.
        function void add_ctrl(logic [7:0] val, logic rs);
            logic [7:0] base;
            logic [7:0] hi;
            logic [7:0] lo;
            logic       slow;
            base = {4'h0, backlight_on, 2'b00, rs};
            hi   = base | {val[7:4], 4'h0};
            lo   = base | {val[3:0], 4'h0};
            slow = !rs && (val <= 8'd3);
            pending_bytes.push_back(t_res'{expander_byte: hi | BIT_E, long_wait: 1'b0, last: 1'b0});
            pending_bytes.push_back(t_res'{expander_byte: hi, long_wait: 1'b0, last: 1'b0});
            pending_bytes.push_back(t_res'{expander_byte: lo | BIT_E, long_wait: 1'b0, last: 1'b0});
            pending_bytes.push_back(t_res'{expander_byte: lo, long_wait: slow, last: 1'b0});
        endfunction

        function void add_ddram_move();
            logic [7:0] addr;
            addr = {2'b00, cursor_col[5:0]};
            if (cursor_row[0]) addr = addr + ROW_ODD_OFFS;
            if (cursor_row[1]) addr = addr + {2'b00, column_count};
            add_ctrl(addr | CMD_SET_DDRAM, 1'b0);
        endfunction

        function void take_request(t_req r);
            case (r.req_type)
                REQ_PUT_CHAR: begin
                    if (r.char_code == CHAR_NEWLINE) begin
                        cursor_col = {1'b0, column_count};
                    end else begin
                        add_ctrl(r.char_code, 1'b1);
                        cursor_col = cursor_col + 7'd1;
                    end
                    if (cursor_col >= {1'b0, column_count}) begin
                        cursor_col = '0;
                        cursor_row = cursor_row + 3'd1;
                    end
                    if (cursor_row >= line_count) cursor_row = '0;
                    add_ddram_move();
                end
                REQ_MOVE: begin
                    cursor_col = {1'b0, r.column};
                    cursor_row = {1'b0, r.row};
                    add_ddram_move();
                end
                REQ_CLEAR: begin
                    add_ctrl(CMD_CLEAR, 1'b0);
                    add_ctrl(CMD_HOME, 1'b0);
                    cursor_col = '0;
                    cursor_row = '0;
                end
                default: begin
                    add_ctrl(r.command_byte, 1'b0);
                end
            endcase
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_byte(t_res got);
            t_res want;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected byte %h", got.expander_byte));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.expander_byte !== want.expander_byte)
                report($sformatf("expander_byte %h, expected %h",
                                 got.expander_byte, want.expander_byte));
            if (got.long_wait !== want.long_wait)
                report($sformatf("long_wait %b, expected %b", got.long_wait, want.long_wait));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       push     = 1'b0;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    t_req       req_bus  = '0;
    t_res       res_bus;
    logic       cfg_we   = 1'b0;
    logic [1:0] cfg_idx  = '0;
    logic [5:0] cfg_data = '0;

    lcd_stream_model sb = new();

    int         sent_items  = 0;
    bit         send_fast   = 1'b0;
    int         idle_cycles = 0;

    logic [2:0] phase_lines [6] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2};
    logic [5:0] phase_cols  [6] = '{6'd1, 6'd40, 6'd0, 6'd63, 6'd20, 6'd16};
    logic       phase_light [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    char_lcd_expander_byte_stream_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (req_bus),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_req make_req(logic [1:0] kind, logic [7:0] ch, logic [5:0] col,
                                      logic [1:0] row, logic [7:0] cmd);
        t_req r;
        r.req_type     = kind;
        r.char_code    = ch;
        r.column       = col;
        r.row          = row;
        r.command_byte = cmd;
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r = make_req(REQ_PUT_CHAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 15);
        if (pick <= 8) begin
            if ($urandom_range(0, 7) == 0) r.char_code = CHAR_NEWLINE;
        end else if (pick <= 11) begin
            r.req_type = REQ_MOVE;
        end else if (pick == 12) begin
            r.req_type = REQ_CLEAR;
        end else begin
            r.req_type = REQ_RAW;
            if ($urandom_range(0, 2) == 0) r.command_byte = 8'($urandom_range(0, 4));
        end
        return r;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        if (sent_items % 16 == 0) send_fast = ($urandom_range(0, 3) == 0);
        gap = send_fast ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        req_bus <= r;
        do @(posedge i_clk); while (full);
        sb.take_request(r);
        sent_items++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] lines, logic [5:0] cols, logic light);
        logic [1:0] idx_list [4];
        logic [5:0] val_list [4];
        idx_list = '{CFG_LINE_COUNT, CFG_COLUMN_COUNT, CFG_BACKLIGHT, CFG_SPARE};
        val_list = '{{3'($urandom), lines}, cols, {5'($urandom), light}, 6'($urandom)};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[i];
            cfg_data <= val_list[i];
            @(posedge i_clk);
            sb.set_register(idx_list[i], val_list[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int   seen;
        bit   fast;
        bit   held;
        int   gap;
        seen = 0;
        fast = 1'b0;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (seen % 16 == 0) fast = ($urandom_range(0, 3) == 0);
            if (!held && seen == 40) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = fast ? 0 : $urandom_range(0, 17);
            repeat (gap) begin
                pop <= 1'b0;
                @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_byte(res_bus);
            seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_req(REQ_PUT_CHAR, 8'h41, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_PUT_CHAR, 8'hff, 6'd63, 2'd3, 8'hff));
        send_request(make_req(REQ_PUT_CHAR, 8'h00, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_PUT_CHAR, CHAR_NEWLINE, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_MOVE, 8'h00, 6'd63, 2'd3, 8'h00));
        send_request(make_req(REQ_MOVE, 8'hff, 6'd0, 2'd0, 8'hff));
        send_request(make_req(REQ_MOVE, 8'h00, 6'd15, 2'd1, 8'h00));
        send_request(make_req(REQ_PUT_CHAR, 8'h5a, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_MOVE, 8'h00, 6'd5, 2'd2, 8'h00));
        send_request(make_req(REQ_PUT_CHAR, 8'h30, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_MOVE, 8'h00, 6'd7, 2'd3, 8'h00));
        send_request(make_req(REQ_PUT_CHAR, CHAR_NEWLINE, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_CLEAR, 8'h00, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_RAW, 8'h00, 6'd0, 2'd0, 8'h00));
        send_request(make_req(REQ_RAW, 8'h00, 6'd0, 2'd0, 8'h03));
        send_request(make_req(REQ_RAW, 8'h00, 6'd0, 2'd0, 8'h04));
        send_request(make_req(REQ_RAW, 8'hff, 6'd63, 2'd3, 8'hff));
        send_request(make_req(REQ_MOVE, 8'h00, 6'd40, 2'd2, 8'h00));

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            configure(phase_lines[p], phase_cols[p], phase_light[p]);
            repeat (19) send_request(random_request());
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
